@@ rtl/verlet_particle_spring_engine_top_assert.svh @@
// Assertion macros shared by the particle engine RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef VERLET_PARTICLE_SPRING_ENGINE_TOP_ASSERT_SVH
`define VERLET_PARTICLE_SPRING_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define VPSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vpse assertion failed");
`define VPSE_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("vpse forbidden condition");
`else
`define VPSE_ASSERT(lbl, prop)
`define VPSE_NEVER(lbl, expr)
`endif
`endif

@@ rtl/vpse_pkg.sv @@
// Shared types, constants and helpers of the particle engine.
// No dependencies.
`timescale 1ns / 1ps
package vpse_pkg;
  localparam int PARTICLE_COUNT = 256;
  localparam int IDX_W = $clog2(PARTICLE_COUNT);

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_FORCE = 3'd1;
  localparam logic [2:0] CMD_STEP  = 3'd2;
  localparam logic [2:0] CMD_SOLVE = 3'd3;
  localparam logic [2:0] CMD_MEAS  = 3'd4;
  localparam logic [2:0] CMD_PIN   = 3'd5;

  localparam logic [1:0] CFG_INV_MASS = 2'd0;
  localparam logic [1:0] CFG_DAMPING  = 2'd1;
  localparam logic [1:0] CFG_TS_SQ    = 2'd2;

  localparam logic [2:0] LOP_IDLE  = 3'd0;
  localparam logic [2:0] LOP_MUL   = 3'd1;
  localparam logic [2:0] LOP_ADD   = 3'd2;
  localparam logic [2:0] LOP_DMUL  = 3'd3;
  localparam logic [2:0] LOP_DINIT = 3'd4;
  localparam logic [2:0] LOP_DSTEP = 3'd5;
  localparam logic [2:0] LOP_FIX   = 3'd6;

  localparam int SQRT_STEPS = 33;
  localparam int DIV_STEPS  = 32;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [31:0] inv_mass;
    logic [16:0] damping;
    logic [16:0] ts_sq;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        e_neg;
    logic [32:0] e_mag;
    logic [33:0] divisor;
  } lane_ctl_t;

  // clamp a wide signed value into 32 bits
  function automatic logic [31:0] sat32(input logic [51:0] v);
    logic fits;
    fits = (&v[51:31]) || (~|v[51:31]);
    if (fits) return v[31:0];
    return v[51] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction
endpackage

@@ rtl/verlet_particle_spring_engine_top.sv @@
// Top level of the Verlet particle engine: sequencer, particle tables,
// three axis lanes and the distance merge. Depends on vpse_pkg, vpse_ram,
// vpse_lane, vpse_sqrt and the assertion header.
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_ready  | cmd, indexes, vector, rest, pin
//   out_    | response  | out_valid/out_ready| position, distance, fault
//   cfg_    | write     | cfg_we             | cfg_index, cfg_wdata
//
// One request at a time. Init, force, step and pin read the rows, run the
// lane multiply and add and write row a; the unused codes skip the write;
// measure and a skipped zero-length solve run the root unit after the add
// and write nothing; solve goes on through the lane divide and fix and writes rows a and b.
// Reset is synchronous, clears control state and loads the config defaults; the particle tables
// hold nothing defined until a particle is initialized.
// A finished result waits in the output register while the next request
// is taken; the sequencer stalls at its last step only if that register is
// still full.
`timescale 1ns / 1ps
`include "verlet_particle_spring_engine_top_assert.svh"
module verlet_particle_spring_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_index_a,
  input  logic [7:0]  in_index_b,
  input  logic [31:0] in_vec_x,
  input  logic [31:0] in_vec_y,
  input  logic [31:0] in_vec_z,
  input  logic [31:0] in_rest_length,
  input  logic        in_pin_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_distance,
  output logic        out_fault,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import vpse_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDA   = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_CAP   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_SQST  = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DMUL  = 4'd8;
  localparam logic [3:0] S_DINIT = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FIX   = 4'd11;
  localparam logic [3:0] S_WRA   = 4'd12;
  localparam logic [3:0] S_WRB   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  localparam int DCNT_W = $clog2(DIV_STEPS);

  // control
  logic [3:0]        state_r, state_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r;
  cfg_t              cfg_r;

  // request hold
  logic [2:0]       cmd_r;
  logic [IDX_W-1:0] ia_r, ib_r;
  vec3_t            vec_r;
  logic [31:0]      rest_r;
  logic             pinf_r;
  logic             fault_r;
  logic [32:0]      len_r;

  // rows read back
  vec3_t pos_a_r, prev_a_r, acc_a_r, pos_b_r;
  logic  pin_a_r, pin_b_r;

  // tables
  logic [IDX_W-1:0] raddr, waddr;
  vec3_t            pos_q, prev_q, acc_q, pos_wd, prev_wd, acc_wd;
  logic             pin_q, pin_wd;
  logic             pos_we, prev_we, acc_we, pin_we;

  // lanes and merge
  lane_ctl_t          lctl;
  logic [2:0]         lop;
  vec3_t              res_acc_w, res_pos_w, new_a_w, new_b_w;
  logic [2:0][63:0]   sq_w;
  logic               sq_start, sq_done;
  logic [32:0]        sq_root;
  logic signed [33:0] err;

  // result
  vec3_t       out_pos_r, out_pos_sel;
  logic [31:0] dist_r;
  logic        fault_out_r;
  logic        accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // length error and divisor for the constraint correction
  assign err          = $signed({1'b0, len_r}) - $signed({2'b0, rest_r});
  assign lctl.e_neg   = err[33];
  assign lctl.e_mag   = err[33] ? 33'(-err) : err[32:0];
  assign lctl.divisor = {len_r, 1'b0};
  assign lctl.op      = lop;

  always_comb begin
    case (state_r)
      S_MUL:   lop = LOP_MUL;
      S_ADD:   lop = LOP_ADD;
      S_DMUL:  lop = LOP_DMUL;
      S_DINIT: lop = LOP_DINIT;
      S_DIV:   lop = LOP_DSTEP;
      S_FIX:   lop = LOP_FIX;
      default: lop = LOP_IDLE;
    endcase
  end

  assign sq_start = (state_r == S_SQST);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDB;
      S_RDB:   state_nxt = S_CAP;
      S_CAP:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD: begin
        case (cmd_r)
          CMD_SOLVE, CMD_MEAS:                    state_nxt = S_SQST;
          CMD_INIT, CMD_FORCE, CMD_STEP, CMD_PIN: state_nxt = S_WRA;
          default:                                state_nxt = S_DONE;
        endcase
      end
      S_SQST:  state_nxt = S_SQRT;
      S_SQRT: begin
        if (sq_done) begin
          if (cmd_r == CMD_SOLVE && sq_root != '0) state_nxt = S_DMUL;
          else                                     state_nxt = S_DONE;
        end
      end
      S_DMUL:  state_nxt = S_DINIT;
      S_DINIT: begin
        state_nxt = S_DIV;
        dcnt_nxt  = '0;
      end
      S_DIV: begin
        dcnt_nxt = DCNT_W'(dcnt_r + 1'b1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) state_nxt = S_FIX;
      end
      S_FIX:   state_nxt = S_WRA;
      S_WRA:   state_nxt = (cmd_r == CMD_SOLVE) ? S_WRB : S_DONE;
      S_WRB:   state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_r.inv_mass <= 32'd65536;
      cfg_r.damping  <= 17'd64881;
      cfg_r.ts_sq    <= 17'd18;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_MASS: cfg_r.inv_mass <= cfg_wdata;
          CFG_DAMPING:  cfg_r.damping  <= cfg_wdata[16:0];
          CFG_TS_SQ:    cfg_r.ts_sq    <= cfg_wdata[16:0];
          default: begin
          end
        endcase
      end
    end
  end

  // hold the request, capture rows, record the distance
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      ia_r    <= IDX_W'(in_index_a);
      ib_r    <= IDX_W'(in_index_b);
      vec_r   <= {in_vec_z, in_vec_y, in_vec_x};
      rest_r  <= in_rest_length;
      pinf_r  <= in_pin_flag;
      fault_r <= 1'b0;
      len_r   <= '0;
    end
    if (state_r == S_RDB) begin
      pos_a_r  <= pos_q;
      prev_a_r <= prev_q;
      acc_a_r  <= acc_q;
      pin_a_r  <= pin_q;
    end
    if (state_r == S_CAP) begin
      pos_b_r <= pos_q;
      pin_b_r <= pin_q;
    end
    if (state_r == S_SQRT && sq_done) begin
      len_r   <= sq_root;
      fault_r <= (cmd_r == CMD_SOLVE) && (sq_root == '0);
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_pos_r   <= out_pos_sel;
      dist_r      <= len_r[32] ? 32'hFFFF_FFFF : len_r[31:0];
      fault_out_r <= fault_r;
    end
  end

  // position of the first particle once the command has taken effect
  always_comb begin
    case (cmd_r)
      CMD_INIT:  out_pos_sel = vec_r;
      CMD_STEP:  out_pos_sel = pin_a_r ? pos_a_r : res_pos_w;
      CMD_SOLVE: out_pos_sel = (pin_a_r || fault_r) ? pos_a_r : new_a_w;
      default:   out_pos_sel = pos_a_r;
    endcase
  end

  // table writes: row a in S_WRA, row b in S_WRB
  assign raddr = (state_r == S_RDA) ? ia_r : ib_r;
  assign waddr = (state_r == S_WRB) ? ib_r : ia_r;

  always_comb begin
    pos_we  = 1'b0;
    prev_we = 1'b0;
    acc_we  = 1'b0;
    pin_we  = 1'b0;
    pos_wd  = pos_a_r;
    prev_wd = pos_a_r;
    acc_wd  = '0;
    pin_wd  = 1'b0;
    if (state_r == S_WRA) begin
      case (cmd_r)
        CMD_INIT: begin
          pos_we  = 1'b1;
          prev_we = 1'b1;
          acc_we  = 1'b1;
          pin_we  = 1'b1;
          pos_wd  = vec_r;
          prev_wd = vec_r;
        end
        CMD_FORCE: begin
          acc_we = !pin_a_r;
          acc_wd = res_acc_w;
        end
        CMD_STEP: begin
          pos_we  = !pin_a_r;
          prev_we = !pin_a_r;
          acc_we  = !pin_a_r;
          pos_wd  = res_pos_w;
        end
        CMD_SOLVE: begin
          pos_we = !pin_a_r;
          pos_wd = new_a_w;
        end
        CMD_PIN: begin
          pin_we = 1'b1;
          pin_wd = pinf_r;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_WRB) begin
      pos_we = !pin_b_r;
      pos_wd = new_b_w;
    end
  end

  vpse_ram #(.WIDTH(96), .DEPTH(PARTICLE_COUNT)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(pos_wd),
    .raddr(raddr), .rdata(pos_q)
  );
  vpse_ram #(.WIDTH(96), .DEPTH(PARTICLE_COUNT)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(waddr), .wdata(prev_wd),
    .raddr(raddr), .rdata(prev_q)
  );
  vpse_ram #(.WIDTH(96), .DEPTH(PARTICLE_COUNT)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(waddr), .wdata(acc_wd),
    .raddr(raddr), .rdata(acc_q)
  );
  vpse_ram #(.WIDTH(1), .DEPTH(PARTICLE_COUNT)) u_pin_ram (
    .clk(clk), .we(pin_we), .waddr(waddr), .wdata(pin_wd),
    .raddr(raddr), .rdata(pin_q)
  );

  // one lane per axis
  for (genvar i = 0; i < 3; i++) begin : g_lane
    vpse_lane u_lane (
      .clk    (clk),
      .ctl    (lctl),
      .cfg    (cfg_r),
      .pos_a  (pos_a_r[i]),
      .prev_a (prev_a_r[i]),
      .acc_a  (acc_a_r[i]),
      .pos_b  (pos_b_r[i]),
      .vec    (vec_r[i]),
      .res_acc(res_acc_w[i]),
      .res_pos(res_pos_w[i]),
      .new_a  (new_a_w[i]),
      .new_b  (new_b_w[i]),
      .sq     (sq_w[i])
    );
  end

  vpse_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .sq_x (sq_w[0]),
    .sq_y (sq_w[1]),
    .sq_z (sq_w[2]),
    .done (sq_done),
    .root (sq_root)
  );

  assign out_valid    = out_valid_r;
  assign out_x        = out_pos_r[0];
  assign out_y        = out_pos_r[1];
  assign out_z        = out_pos_r[2];
  assign out_distance = dist_r;
  assign out_fault    = fault_out_r;

  `VPSE_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r) == S_DONE)
  `VPSE_ASSERT(a_wrb_after_wra, state_r == S_WRB |-> $past(state_r) == S_WRA)
  `VPSE_ASSERT(a_wrb_solve_only, state_r == S_WRB |-> cmd_r == CMD_SOLVE)
  `VPSE_NEVER(a_root_unexpected, sq_done && state_r != S_SQRT)
  `VPSE_ASSERT(a_fault_zero_dist, out_valid_r && out_fault |-> out_distance == 32'd0)
endmodule

@@ rtl/vpse_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module vpse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/vpse_lane.sv @@
// One axis lane: force, Verlet step, delta square and the constraint divide.
// Depends on vpse_pkg.
`timescale 1ns / 1ps
module vpse_lane (
  input  logic                clk,
  input  vpse_pkg::lane_ctl_t ctl,
  input  vpse_pkg::cfg_t      cfg,
  input  logic [31:0]         pos_a,
  input  logic [31:0]         prev_a,
  input  logic [31:0]         acc_a,
  input  logic [31:0]         pos_b,
  input  logic [31:0]         vec,
  output logic [31:0]         res_acc,
  output logic [31:0]         res_pos,
  output logic [31:0]         new_a,
  output logic [31:0]         new_b,
  output logic [63:0]         sq
);
  import vpse_pkg::*;

  logic signed [64:0] fprod_r, fprod_nxt;
  logic signed [50:0] vprod_r, vprod_nxt;
  logic signed [49:0] aprod_r, aprod_nxt;
  logic signed [32:0] d_r, d_nxt;
  logic [31:0] res_acc_r, res_acc_nxt, res_pos_r, res_pos_nxt;
  logic [31:0] new_a_r, new_a_nxt, new_b_r, new_b_nxt;
  logic [63:0] sq_r, sq_nxt;
  logic [64:0] dvd_r, dvd_nxt;
  logic        neg_r, neg_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] sh_r, sh_nxt, q_r, q_nxt;

  logic signed [32:0] im_s;
  logic signed [17:0] damp_s, ts_s;
  logic signed [32:0] vel_diff;
  logic [32:0] d_abs;
  logic [34:0] trial;
  logic signed [32:0] corr;

  assign im_s     = {1'b0, cfg.inv_mass};
  assign damp_s   = {1'b0, cfg.damping};
  assign ts_s     = {1'b0, cfg.ts_sq};
  assign vel_diff = 33'($signed(pos_a)) - 33'($signed(prev_a));
  assign d_abs    = d_r[32] ? 33'(-d_r) : 33'(d_r);
  assign trial    = {rem_r, sh_r[31]};
  assign corr     = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  always_comb begin
    fprod_nxt   = fprod_r;
    vprod_nxt   = vprod_r;
    aprod_nxt   = aprod_r;
    d_nxt       = d_r;
    res_acc_nxt = res_acc_r;
    res_pos_nxt = res_pos_r;
    new_a_nxt   = new_a_r;
    new_b_nxt   = new_b_r;
    sq_nxt      = sq_r;
    dvd_nxt     = dvd_r;
    neg_nxt     = neg_r;
    rem_nxt     = rem_r;
    sh_nxt      = sh_r;
    q_nxt       = q_r;
    case (ctl.op)
      LOP_MUL: begin
        fprod_nxt = $signed(vec) * im_s;
        vprod_nxt = vel_diff * damp_s;
        aprod_nxt = $signed(acc_a) * ts_s;
        d_nxt     = 33'($signed(pos_b)) - 33'($signed(pos_a));
      end
      LOP_ADD: begin
        res_acc_nxt = sat32(52'($signed(acc_a)) + 52'(fprod_r >>> 16));
        res_pos_nxt = sat32(52'($signed(pos_a)) + 52'(vprod_r >>> 16)
                            + 52'(aprod_r >>> 16));
        sq_nxt      = d_abs[31:0] * d_abs[31:0];
      end
      LOP_DMUL: begin
        dvd_nxt = d_abs[31:0] * ctl.e_mag;
        neg_nxt = d_r[32] ^ ctl.e_neg;
      end
      LOP_DINIT: begin
        rem_nxt = {1'b0, dvd_r[64:32]};
        sh_nxt  = dvd_r[31:0];
        q_nxt   = '0;
      end
      LOP_DSTEP: begin
        // one quotient bit per cycle, restoring form
        if (trial >= {1'b0, ctl.divisor}) begin
          rem_nxt = 34'(trial - {1'b0, ctl.divisor});
          q_nxt   = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = trial[33:0];
          q_nxt   = {q_r[30:0], 1'b0};
        end
        sh_nxt = {sh_r[30:0], 1'b0};
      end
      LOP_FIX: begin
        new_a_nxt = sat32(52'($signed(pos_a)) + 52'(corr));
        new_b_nxt = sat32(52'($signed(pos_b)) - 52'(corr));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    fprod_r   <= fprod_nxt;
    vprod_r   <= vprod_nxt;
    aprod_r   <= aprod_nxt;
    d_r       <= d_nxt;
    res_acc_r <= res_acc_nxt;
    res_pos_r <= res_pos_nxt;
    new_a_r   <= new_a_nxt;
    new_b_r   <= new_b_nxt;
    sq_r      <= sq_nxt;
    dvd_r     <= dvd_nxt;
    neg_r     <= neg_nxt;
    rem_r     <= rem_nxt;
    sh_r      <= sh_nxt;
    q_r       <= q_nxt;
  end

  assign res_acc = res_acc_r;
  assign res_pos = res_pos_r;
  assign new_a   = new_a_r;
  assign new_b   = new_b_r;
  assign sq      = sq_r;
endmodule

@@ rtl/vpse_sqrt.sv @@
// Merge stage: sums the lane squares and takes the integer square root,
// two radicand bits per cycle. Depends on vpse_pkg.
`timescale 1ns / 1ps
module vpse_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] sq_x,
  input  logic [63:0] sq_y,
  input  logic [63:0] sq_z,
  output logic        done,
  output logic [32:0] root
);
  import vpse_pkg::*;

  localparam int CNT_W = $clog2(SQRT_STEPS);

  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [65:0]      rad_r, rad_nxt;
  logic [34:0]      rem_r, rem_nxt;
  logic [32:0]      root_r, root_nxt;
  logic [36:0]      t;
  logic [34:0]      trial;

  assign t     = {rem_r, rad_r[65:64]};
  assign trial = {root_r[32:0], 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = 66'(sq_x) + 66'(sq_y) + 66'(sq_z);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (t >= 37'(trial)) begin
        rem_nxt  = 35'(t - 37'(trial));
        root_nxt = {root_r[31:0], 1'b1};
      end else begin
        rem_nxt  = t[34:0];
        root_nxt = {root_r[31:0], 1'b0};
      end
      rad_nxt = {rad_r[63:0], 2'b00};
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
      if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule
